### hdl/gfre_pkg.sv
// shared types and constants for the givens feature row elimination core
`default_nettype none
package gfre_pkg;

  localparam int MAX_ROWS      = 32;
  localparam int FEAT_COLS     = 3;
  localparam int STATE_COLS    = 16;
  localparam int ELEMS_PER_ROW = FEAT_COLS + STATE_COLS + 1;
  localparam int FEAT_DEPTH    = MAX_ROWS * FEAT_COLS;
  localparam int STATE_DEPTH   = MAX_ROWS * STATE_COLS;

  localparam logic [4:0] K_STATE_BASE = 5'(FEAT_COLS);
  localparam logic [4:0] K_RESID      = 5'(FEAT_COLS + STATE_COLS);
  localparam logic [4:0] K_LAST       = 5'(ELEMS_PER_ROW - 1);

  localparam logic [2:0] CMD_LOAD_FEAT  = 3'd0;
  localparam logic [2:0] CMD_LOAD_STATE = 3'd1;
  localparam logic [2:0] CMD_LOAD_RESID = 3'd2;
  localparam logic [2:0] CMD_RUN        = 3'd3;
  localparam logic [2:0] CMD_READ       = 3'd4;

  localparam logic [1:0] MAT_FEAT  = 2'd0;
  localparam logic [1:0] MAT_STATE = 2'd1;
  localparam logic [1:0] MAT_RESID = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ODD   = 2'd1;
  localparam logic [1:0] STATUS_LARGE = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [1:0]         read_matrix;
    logic [4:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] elem_value;
    logic [5:0]         row_count;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [5:0]         surviving_rows;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_OUT, ST_COL_START, ST_P_RDA, ST_P_RDB, ST_P_CHK, ST_P_TST,
    ST_SQ_A, ST_SQ_B, ST_SQ_S, ST_SQRT, ST_RAD_CHK, ST_DIV_C, ST_DIV_S, ST_SIGN,
    ST_R_RDU, ST_R_RDV, ST_R_M1, ST_R_M2, ST_R_M3, ST_R_M4, ST_R_M5,
    ST_NEXT_PAIR, ST_SH_START, ST_SH_RD, ST_SH_WR, ST_DONE
  } state_t;

endpackage
`default_nettype wire

### hdl/givens_feature_row_elimination_core.sv
// givens rotation feature elimination core with element-wise load and read back
//
//  channel         | direction | payload
//  req             | in        | gfre_pkg::req_t (cmd, indices, value, row count)
//  rsp             | out       | gfre_pkg::rsp_t (read value, surviving rows, status)
//  zero_threshold  | in        | write enable plus 16-bit data, no handshake
//
// loads, rejected runs and unused codes answer the cycle after the transfer, reads after ST_RD_OUT
// a run walks adjacent row pairs per feature column from the bottom up: ST_P_RDA..ST_P_TST
// fetch and test the pair, ST_SQ_A..ST_SQ_S the square sum, a 32-step square root, two 32-step
// dividers and a sign step, ST_R_RDU..ST_R_M5 each stored element, the row shift a read and a
// write per moved element; one shared multiplier serves the squares and the rotation products
// reset (synchronous, active high) clears control and rows_left, not the stores
// req_ready is low while a command works and while an unread response blocks
`default_nettype none
module givens_feature_row_elimination_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire gfre_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output gfre_pkg::rsp_t      rsp,
  input  wire logic           zero_threshold_we,
  input  wire logic [15:0]    zero_threshold_wdata
);
  import gfre_pkg::*;

  // round a Q2.30 x Q16.16 product sum back to Q16.16 and saturate
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = (x + 64'sd536870912) >>> 30;
    if (t > 64'sd2147483647) return 32'sh7fffffff;
    else if (t < -64'sd2147483648) return 32'sh80000000;
    else return t[31:0];
  endfunction

  state_t state, state_next;

  logic [15:0] zero_threshold;
  logic [5:0]  rows_left;
  logic [5:0]  rows;
  logic [1:0]  col;
  logic [4:0]  r;
  logic [4:0]  k;
  logic [4:0]  k_q;
  logic [4:0]  it;
  logic        rd_ok;

  logic signed [31:0] a, b, u, v, c_rot, s_rot;
  logic [31:0] ma, mb;
  logic [31:0] cm, sm;

  // shared multiplier and accumulator
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod, acc;

  // square root and divider state
  logic [63:0] sq;
  logic [33:0] remd;
  logic [31:0] res;
  logic [33:0] remd_sh, trial;
  logic [32:0] drem, dtry;
  logic [31:0] nlo, quo;
  logic [62:0] num_c, num_s;

  // stores
  logic signed [31:0] feat_mem  [FEAT_DEPTH];
  logic signed [31:0] state_mem [STATE_DEPTH];
  logic signed [31:0] resid_mem [MAX_ROWS];
  logic signed [31:0] feat_q, state_q, resid_q, elem_q;

  // access controls
  logic [4:0]  acc_row, acc_k;
  logic [1:0]  mat;
  logic [6:0]  feat_addr;
  logic [8:0]  state_addr;
  logic [3:0]  kst;
  logic        wr, feat_we, state_we, resid_we;
  logic signed [31:0] wdata;
  logic signed [31:0] u_new, v_new;
  logic        req_xfer, run_ok, load_cmd;

  assign req_xfer = req_valid && req_ready;
  assign run_ok   = (req.row_count <= 6'(MAX_ROWS)) && !req.row_count[0];
  assign load_cmd = (req.cmd == CMD_LOAD_FEAT) || (req.cmd == CMD_LOAD_STATE) ||
                    (req.cmd == CMD_LOAD_RESID);
  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);

  assign ma = a[31] ? 32'(-a) : 32'(a);
  assign mb = b[31] ? 32'(-b) : 32'(b);
  assign u_new = round_sat(acc - prod);
  assign v_new = round_sat(acc + prod);

  assign mul_full = mul_x * mul_y;

  // square root digit step
  assign remd_sh = {remd[31:0], sq[63:62]};
  assign trial   = {res, 2'b01};
  // divider step
  assign dtry  = {drem[31:0], nlo[31]};
  assign num_c = ({31'd0, ma} << 30) + {32'd0, res[31:1]};
  assign num_s = ({31'd0, mb} << 30) + {32'd0, res[31:1]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          if (req.cmd == CMD_READ) state_next = ST_RD_OUT;
          else if (req.cmd == CMD_RUN && run_ok) state_next = ST_COL_START;
        end
      end
      ST_RD_OUT:    state_next = ST_IDLE;
      ST_COL_START: begin
        if (col == 2'(FEAT_COLS)) state_next = ST_SH_START;
        else if (rows >= 6'(col) + 6'd2) state_next = ST_P_RDA;
      end
      ST_P_RDA:   state_next = ST_P_RDB;
      ST_P_RDB:   state_next = ST_P_CHK;
      ST_P_CHK:   state_next = ST_P_TST;
      ST_P_TST:   state_next = (mb < {16'd0, zero_threshold}) ? ST_NEXT_PAIR : ST_SQ_A;
      ST_SQ_A:    state_next = ST_SQ_B;
      ST_SQ_B:    state_next = ST_SQ_S;
      ST_SQ_S:    state_next = ST_SQRT;
      ST_SQRT:    if (it == 5'd31) state_next = ST_RAD_CHK;
      ST_RAD_CHK: state_next = (res == 32'd0) ? ST_NEXT_PAIR : ST_DIV_C;
      ST_DIV_C:   if (it == 5'd31) state_next = ST_DIV_S;
      ST_DIV_S:   if (it == 5'd31) state_next = ST_SIGN;
      ST_SIGN:    state_next = ST_R_RDU;
      ST_R_RDU:   state_next = ST_R_RDV;
      ST_R_RDV:   state_next = ST_R_M1;
      ST_R_M1:    state_next = ST_R_M2;
      ST_R_M2:    state_next = ST_R_M3;
      ST_R_M3:    state_next = ST_R_M4;
      ST_R_M4:    state_next = ST_R_M5;
      ST_R_M5:    state_next = (k == K_LAST) ? ST_NEXT_PAIR : ST_R_RDU;
      ST_NEXT_PAIR: state_next = (r == 5'(col)) ? ST_COL_START : ST_P_RDA;
      ST_SH_START:  state_next = (rows <= 6'(FEAT_COLS)) ? ST_DONE : ST_SH_RD;
      ST_SH_RD:     state_next = ST_SH_WR;
      ST_SH_WR: begin
        if (k == K_LAST && 6'(r) == rows - 6'(FEAT_COLS + 1)) state_next = ST_DONE;
        else state_next = ST_SH_RD;
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // access controls and multiplier operands
  always_comb begin
    acc_row = r;
    acc_k   = k;
    wr      = 1'b0;
    wdata   = elem_q;
    mul_x   = '0;
    mul_y   = '0;
    mat     = load_cmd ? req.cmd[1:0] : req.read_matrix;
    unique case (state)
      ST_IDLE: begin
        acc_row = req.row_index;
        case (mat)
          MAT_FEAT:  acc_k = {1'b0, req.col_index};
          MAT_STATE: acc_k = {1'b0, req.col_index} + K_STATE_BASE;
          default:   acc_k = K_RESID;
        endcase
        // a feature load past the last feature column is dropped
        wr    = req_xfer && load_cmd &&
                !(req.cmd == CMD_LOAD_FEAT && req.col_index >= 4'(FEAT_COLS));
        wdata = req.elem_value;
      end
      ST_P_RDA: acc_k = 5'(col);
      ST_P_RDB: begin
        acc_row = r + 5'd1;
        acc_k   = 5'(col);
      end
      ST_SQ_A: begin
        mul_x = {1'b0, ma};
        mul_y = {1'b0, ma};
      end
      ST_SQ_B: begin
        mul_x = {1'b0, mb};
        mul_y = {1'b0, mb};
      end
      ST_R_RDV: acc_row = r + 5'd1;
      ST_R_M1: begin
        mul_x = 33'(c_rot);
        mul_y = 33'(u);
      end
      ST_R_M2: begin
        mul_x = 33'(s_rot);
        mul_y = 33'(v);
      end
      ST_R_M3: begin
        mul_x = 33'(s_rot);
        mul_y = 33'(u);
        wr    = 1'b1;
        wdata = u_new;
      end
      ST_R_M4: begin
        mul_x = 33'(c_rot);
        mul_y = 33'(v);
      end
      ST_R_M5: begin
        acc_row = r + 5'd1;
        wr      = 1'b1;
        wdata   = v_new;
      end
      ST_SH_RD: acc_row = r + 5'(FEAT_COLS);
      ST_SH_WR: wr = 1'b1;
      default: ;
    endcase
  end

  // element index splits into the three stores
  assign kst        = 4'(acc_k - K_STATE_BASE);
  assign feat_addr  = 7'({2'b0, acc_row} * 7'(FEAT_COLS)) + {5'd0, acc_k[1:0]};
  assign state_addr = {acc_row, kst};
  assign feat_we  = wr && (acc_k < K_STATE_BASE) &&
                    !(state == ST_IDLE && req.col_index >= 4'(FEAT_COLS));
  assign state_we = wr && (acc_k >= K_STATE_BASE) && (acc_k < K_RESID);
  assign resid_we = wr && (acc_k == K_RESID);

  always_ff @(posedge clk) begin
    if (feat_we) feat_mem[feat_addr] <= wdata;
    feat_q <= feat_mem[feat_addr];
  end

  always_ff @(posedge clk) begin
    if (state_we) state_mem[state_addr] <= wdata;
    state_q <= state_mem[state_addr];
  end

  always_ff @(posedge clk) begin
    if (resid_we) resid_mem[acc_row] <= wdata;
    resid_q <= resid_mem[acc_row];
  end

  always_comb begin
    if (k_q < K_STATE_BASE) elem_q = feat_q;
    else if (k_q < K_RESID) elem_q = state_q;
    else elem_q = resid_q;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      zero_threshold <= 16'd1;
      rows_left      <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (zero_threshold_we) zero_threshold <= zero_threshold_wdata;
      if ((state == ST_IDLE && req_xfer && req.cmd != CMD_READ &&
           !(req.cmd == CMD_RUN && run_ok)) ||
          state == ST_RD_OUT || state == ST_DONE) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (state == ST_SH_START && rows <= 6'(FEAT_COLS)) rows_left <= '0;
      if (state == ST_SH_WR && state_next == ST_DONE)
        rows_left <= rows - 6'(FEAT_COLS);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    k_q  <= acc_k;
    prod <= mul_full[63:0];
    unique case (state)
      ST_IDLE: begin
        rows  <= req.row_count;
        col   <= '0;
        rd_ok <= (req.read_matrix == MAT_RESID) || (req.read_matrix == MAT_STATE) ||
                 (req.read_matrix == MAT_FEAT && req.col_index < 4'(FEAT_COLS));
        // the response holds still while it waits
        if (req_xfer) begin
          rsp.read_value     <= '0;
          rsp.surviving_rows <= rows_left;
          if (req.cmd == CMD_RUN && req.row_count > 6'(MAX_ROWS)) rsp.status <= STATUS_LARGE;
          else if (req.cmd == CMD_RUN && req.row_count[0]) rsp.status <= STATUS_ODD;
          else rsp.status <= STATUS_OK;
        end
      end
      ST_RD_OUT: rsp.read_value <= rd_ok ? elem_q : 32'sd0;
      ST_COL_START: begin
        if (col != 2'(FEAT_COLS)) begin
          if (rows >= 6'(col) + 6'd2) r <= 5'(rows - 6'd2);
          else col <= col + 2'd1;
        end
      end
      ST_P_RDB: a <= elem_q;
      ST_P_CHK: b <= elem_q;
      ST_SQ_B:  acc <= prod;
      ST_SQ_S: begin
        sq   <= 64'(acc) + 64'(prod);
        remd <= '0;
        res  <= '0;
        it   <= '0;
      end
      ST_SQRT: begin
        sq <= sq << 2;
        it <= it + 5'd1;
        if (remd_sh >= trial) begin
          remd <= remd_sh - trial;
          res  <= {res[30:0], 1'b1};
        end else begin
          remd <= remd_sh;
          res  <= {res[30:0], 1'b0};
        end
      end
      ST_RAD_CHK: begin
        drem <= {2'b0, num_c[62:32]};
        nlo  <= num_c[31:0];
        it   <= '0;
      end
      ST_DIV_C, ST_DIV_S: begin
        it  <= it + 5'd1;
        quo <= {quo[30:0], (dtry >= {1'b0, res})};
        if (it == 5'd31 && state == ST_DIV_C) begin
          // cosine done, load the sine numerator
          cm   <= {quo[30:0], (dtry >= {1'b0, res})};
          drem <= {2'b0, num_s[62:32]};
          nlo  <= num_s[31:0];
        end else begin
          nlo <= nlo << 1;
          if (dtry >= {1'b0, res}) drem <= dtry - {1'b0, res};
          else drem <= dtry;
        end
        if (it == 5'd31 && state == ST_DIV_S) sm <= {quo[30:0], (dtry >= {1'b0, res})};
      end
      ST_SIGN: begin
        k <= '0;
        if (mb > ma) begin
          s_rot <= sm;
          c_rot <= (a[31] == b[31]) ? -$signed(cm) : $signed(cm);
        end else begin
          c_rot <= cm;
          s_rot <= (a[31] == b[31]) ? -$signed(sm) : $signed(sm);
        end
      end
      ST_R_RDV: u <= elem_q;
      ST_R_M1:  v <= elem_q;
      ST_R_M2:  acc <= prod;
      ST_R_M4:  acc <= prod;
      ST_R_M5:  if (k != K_LAST) k <= k + 5'd1;
      ST_NEXT_PAIR: begin
        if (r == 5'(col)) col <= col + 2'd1;
        else r <= r - 5'd1;
      end
      ST_SH_START: begin
        r <= '0;
        k <= '0;
      end
      ST_SH_WR: begin
        if (k == K_LAST) begin
          k <= '0;
          r <= r + 5'd1;
        end else begin
          k <= k + 5'd1;
        end
      end
      ST_DONE: begin
        rsp.read_value     <= '0;
        rsp.surviving_rows <= rows_left;
        rsp.status         <= STATUS_OK;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### tb/tb.sv
// self-checking testbench for the givens feature row elimination core
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gfre_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        zero_threshold_we = 1'b0;
  logic [15:0] zero_threshold_wdata = '0;

  givens_feature_row_elimination_core i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .req_valid            (req_valid),
    .req_ready            (req_ready),
    .req                  (req),
    .rsp_valid            (rsp_valid),
    .rsp_ready            (rsp_ready),
    .rsp                  (rsp),
    .zero_threshold_we    (zero_threshold_we),
    .zero_threshold_wdata (zero_threshold_wdata)
  );

  // ---------------------------------------------------------------------
  // predictor state: its own copy of the three stores and the threshold
  // ---------------------------------------------------------------------
  longint          feat_mem  [FEAT_DEPTH];
  longint          state_mem [STATE_DEPTH];
  longint          resid_mem [MAX_ROWS];
  int              rows_kept;
  longint unsigned thresh;

  req_t pending_reqs[$];   // items not yet handed to the driver
  rsp_t expected_rsps[$];  // predicted responses, oldest first

  int     fail_count;
  int     n_loads, n_reads, n_runs, n_rotations, n_checked;
  bit     calm;            // no idling on either side
  int     idle_odds;       // one idle burst start in idle_odds cycles
  longint cycle_count;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // bitwise integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rounded q2.30 product sums, then saturated back to the data range
  function automatic void rotate_vals(input longint u, input longint v, input longint c,
                                      input longint s, output longint nu, output longint nv);
    nu = clamp32((c * u - s * v + (64'sd1 << 29)) >>> 30);
    nv = clamp32((s * u + c * v + (64'sd1 << 29)) >>> 30);
  endfunction

  // full sweep of one run command: rotations per feature column, then row shift
  function automatic void eliminate_rows(int rows);
    longint a, b, c, s, x, y;
    longint unsigned ma, mb, rad, cm, sm;
    bit same;
    for (int col = 0; col < FEAT_COLS; col++) begin
      for (int r = rows - 2; r >= col; r--) begin
        a = feat_mem[r*FEAT_COLS + col];
        b = feat_mem[(r+1)*FEAT_COLS + col];
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        if (mb < thresh) continue;
        rad = floor_sqrt(ma*ma + mb*mb);
        if (rad == 0) continue;           // zero pair
        cm = ((ma << 30) + rad/2) / rad;
        sm = ((mb << 30) + rad/2) / rad;
        same = (a < 0) == (b < 0);
        if (mb > ma) begin
          s = sm;
          c = same ? -longint'(cm) : longint'(cm);
        end else begin
          c = cm;
          s = same ? -longint'(sm) : longint'(sm);
        end
        n_rotations++;
        for (int k = 0; k < FEAT_COLS; k++) begin
          rotate_vals(feat_mem[r*FEAT_COLS+k], feat_mem[(r+1)*FEAT_COLS+k], c, s, x, y);
          feat_mem[r*FEAT_COLS+k] = x;
          feat_mem[(r+1)*FEAT_COLS+k] = y;
        end
        for (int k = 0; k < STATE_COLS; k++) begin
          rotate_vals(state_mem[r*STATE_COLS+k], state_mem[(r+1)*STATE_COLS+k],
                      c, s, x, y);
          state_mem[r*STATE_COLS+k] = x;
          state_mem[(r+1)*STATE_COLS+k] = y;
        end
        rotate_vals(resid_mem[r], resid_mem[r+1], c, s, x, y);
        resid_mem[r] = x;
        resid_mem[r+1] = y;
      end
    end
    // few rows: nothing survives and nothing moves
    if (rows <= FEAT_COLS) begin
      rows_kept = 0;
      return;
    end
    for (int r = 0; r < rows - FEAT_COLS; r++) begin
      resid_mem[r] = resid_mem[r + FEAT_COLS];
      for (int k = 0; k < STATE_COLS; k++)
        state_mem[r*STATE_COLS+k] = state_mem[(r+FEAT_COLS)*STATE_COLS+k];
      for (int k = 0; k < FEAT_COLS; k++)
        feat_mem[r*FEAT_COLS+k] = feat_mem[(r+FEAT_COLS)*FEAT_COLS+k];
    end
    rows_kept = rows - FEAT_COLS;
  endfunction

  // expected response for one accepted request, updating the predictor state
  function automatic rsp_t predict_response(req_t q);
    rsp_t   o;
    longint rd;
    int     row, col, cnt;
    rd  = 0;
    row = q.row_index;
    col = q.col_index;
    cnt = q.row_count;
    o   = '0;
    case (q.cmd)
      CMD_LOAD_FEAT: begin
        n_loads++;
        if (col < FEAT_COLS) feat_mem[row*FEAT_COLS + col] = q.elem_value;
      end
      CMD_LOAD_STATE: begin
        n_loads++;
        if (col < STATE_COLS) state_mem[row*STATE_COLS + col] = q.elem_value;
      end
      CMD_LOAD_RESID: begin
        n_loads++;
        resid_mem[row] = q.elem_value;
      end
      CMD_RUN: begin
        n_runs++;
        if (cnt > MAX_ROWS) o.status = STATUS_LARGE;
        else if (cnt[0]) o.status = STATUS_ODD;
        else eliminate_rows(cnt);
      end
      CMD_READ: begin
        n_reads++;
        if (q.read_matrix == MAT_FEAT && col < FEAT_COLS) rd = feat_mem[row*FEAT_COLS + col];
        else if (q.read_matrix == MAT_STATE && col < STATE_COLS)
          rd = state_mem[row*STATE_COLS + col];
        else if (q.read_matrix == MAT_RESID) rd = resid_mem[row];
      end
      default: ;  // unused codes leave everything alone
    endcase
    o.read_value     = rd[31:0];
    o.surviving_rows = 6'(rows_kept);
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t after %0d cycles", $time, cycle_count);
      $display("[givens_feature_row_elimination_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // request driver: holds valid and payload until the transfer, random gaps
  // ---------------------------------------------------------------------
  int req_gap;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else if (!req_valid || req_ready) begin
      if (req_gap > 0) begin
        req_gap   <= req_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        if (!calm && $urandom_range(idle_odds - 1) == 0) begin
          req_gap   <= $urandom_range(12);
          req_valid <= 1'b0;
        end else begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response side back-pressure in bursts
  int rsp_gap;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_gap   <= 0;
    end else if (rsp_gap > 0) begin
      rsp_gap   <= rsp_gap - 1;
      rsp_ready <= 1'b0;
    end else if (!calm && $urandom_range(idle_odds - 1) == 0) begin
      rsp_gap   <= $urandom_range(12);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: predict on request transfer first, then check response transfer
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_rsps.push_back(predict_response(req));
      if (rsp_valid && rsp_ready) begin
        n_checked++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, actual %0d",
                     $time, want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.surviving_rows !== want.surviving_rows) begin
            $display("%0t: surviving_rows mismatch, expected %0d, actual %0d",
                     $time, want.surviving_rows, rsp.surviving_rows);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp.status);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  function automatic req_t make_req(logic [2:0] cmd, int mat, int row, int col,
                                    logic [31:0] val, int cnt);
    req_t q;
    q.cmd         = cmd;
    q.read_matrix = 2'(mat);
    q.row_index   = 5'(row);
    q.col_index   = 4'(col);
    q.elem_value  = val;
    q.row_count   = 6'(cnt);
    return q;
  endfunction

  // mostly moderate values so rotations stay meaningful, some full-range and extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($urandom_range(3)) - 32'd1;
      default: return 32'($urandom_range(32'h7ffff)) - 32'h40000;
    endcase
  endfunction

  // mostly small even row counts, the full height now and then, some odd or too large counts
  function automatic int pick_rows();
    int p;
    p = $urandom_range(99);
    if (p < 3) return MAX_ROWS;
    if (p < 8) return $urandom_range(1) ? 2 * $urandom_range(16) + 1 : $urandom_range(63, 33);
    return 2 * $urandom_range(5);
  endfunction

  function automatic req_t random_req();
    int p;
    p = $urandom_range(99);
    if (p < 15) return make_req(CMD_LOAD_FEAT, $urandom, $urandom, $urandom_range(3),
                                pick_value(), $urandom);
    if (p < 33) return make_req(CMD_LOAD_STATE, $urandom, $urandom, $urandom, pick_value(),
                                $urandom);
    if (p < 42) return make_req(CMD_LOAD_RESID, $urandom, $urandom, $urandom, pick_value(),
                                $urandom);
    if (p < 46) return make_req(CMD_RUN, $urandom, $urandom, $urandom, $urandom, pick_rows());
    if (p < 48) return make_req(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom,
                                $urandom, $urandom);
    return make_req(CMD_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) @(posedge clk);
    // no run can still be busy once nothing is expected, so a short pause is enough
    repeat (10) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    zero_threshold_we    <= 1'b1;
    zero_threshold_wdata <= v;
    @(posedge clk);
    zero_threshold_we    <= 1'b0;
    thresh = v;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] phase_thresh [4];
    fail_count = 0; n_loads = 0; n_reads = 0; n_runs = 0; n_rotations = 0; n_checked = 0;
    cycle_count = 0;
    calm = 1'b0;
    idle_odds = 8;
    rows_kept = 0;
    thresh = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every entry of all three stores so no read or run touches stale data
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int k = 0; k < FEAT_COLS; k++)
        pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, r, k, pick_value(), 0));
      for (int k = 0; k < STATE_COLS; k++)
        pending_reqs.push_back(make_req(CMD_LOAD_STATE, 0, r, k, pick_value(), 0));
      pending_reqs.push_back(make_req(CMD_LOAD_RESID, 0, r, 0, pick_value(), 0));
    end

    // directed corners at the reset threshold
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, 33));        // too large
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, 63));
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, 7));         // odd
    pending_reqs.push_back(make_req(3'd5, 3, 31, 15, 32'hffffffff, 63));
    pending_reqs.push_back(make_req(3'd7, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(CMD_READ, 3, 31, 15, 0, 0));      // bad matrix select
    pending_reqs.push_back(make_req(CMD_READ, MAT_FEAT, 4, 3, 0, 0)); // column out of range
    pending_reqs.push_back(make_req(CMD_READ, MAT_RESID, 31, 15, 0, 0));
    pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 0, 15, 32'h1234, 0)); // ignored load
    // extreme pair forces saturation in the rotation
    pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 0, 0, 32'h7fffffff, 0));
    pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 1, 0, 32'h80000000, 0));
    pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 0, 1, 32'h80000000, 0));
    pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 1, 1, 32'h80000000, 0));
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, 2));         // few rows
    pending_reqs.push_back(make_req(CMD_READ, MAT_FEAT, 0, 1, 0, 0));
    pending_reqs.push_back(make_req(CMD_READ, MAT_FEAT, 1, 1, 0, 0));
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, 0));
    // zero pair: both rows zero in every feature column
    for (int k = 0; k < FEAT_COLS; k++) begin
      pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 2, k, 0, 0));
      pending_reqs.push_back(make_req(CMD_LOAD_FEAT, 0, 3, k, 0, 0));
    end
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, 4));
    pending_reqs.push_back(make_req(CMD_RUN, 0, 0, 0, 0, MAX_ROWS));  // full height
    pending_reqs.push_back(make_req(CMD_READ, MAT_STATE, 28, 15, 0, 0));
    wait_idle();

    // threshold settings: off, maximum, random and minimum-ish
    phase_thresh[0] = 16'd0;
    phase_thresh[1] = 16'hffff;
    phase_thresh[2] = 16'($urandom);
    phase_thresh[3] = 16'd1;
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(phase_thresh[ph]);
      idle_odds = (ph == 1) ? 3 : 8;
      calm = (ph == 3);
      for (int i = 0; i < 340; i++) pending_reqs.push_back(random_req());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d loads, %0d reads, %0d run commands with %0d rotations",
             n_loads, n_reads, n_runs, n_rotations);
    $display("checked %0d response transfers, %0d left unmatched",
             n_checked, expected_rsps.size());
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("[givens_feature_row_elimination_core] OK");
    end else begin
      $display("[givens_feature_row_elimination_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

### givens_feature_row_elimination_core.f
hdl/gfre_pkg.sv
hdl/givens_feature_row_elimination_core.sv
tb/tb.sv
